// File: rtl/core/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg: shared types and constants of the 4x4 vertex transform
// Fixed-point formats, accumulator sizing and the coefficient register map.
// ----------------------------------------------------------------------------
package vt4_pkg;

  // Number format of coefficients and coordinates
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Matrix and register map
  localparam int DIM      = 4;
  localparam int NUM_REGS = 2 * DIM;
  localparam int REG_W    = 64;
  localparam int SLOT_W   = 32;
  localparam int FIELD_W  = 32;
  localparam int IDX_W    = $clog2(NUM_REGS);

  // Exact product and sum widths: four full products plus the rounding half
  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int ACC_W  = PROD_W + 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [FIELD_W-1:0]     field_t;
  typedef logic        [REG_W-1:0]       reg_t;
  typedef logic        [IDX_W-1:0]       reg_idx_t;

  typedef coord_t     coord_vec_t [DIM];
  typedef prod_t      prod_vec_t  [DIM];
  typedef acc_t       acc_vec_t   [DIM];
  typedef coord_vec_t coef_mat_t  [DIM];

  localparam coord_t COEF_ONE   = coord_t'(64'd1 << FRAC_BITS);
  localparam acc_t   ROUND_HALF = acc_t'(64'd1 << (FRAC_BITS - 1));
  localparam coord_t COORD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Register holding row r, column c: two columns per register
  function automatic reg_idx_t coef_reg(input int r, input int c);
    return reg_idx_t'(2 * r + (c >> 1));
  endfunction

  // Bit offset of column c inside its register
  function automatic int coef_lsb(input int c);
    return (c & 1) * SLOT_W;
  endfunction

  // Reset value of a register: identity matrix
  function automatic reg_t reg_reset(input int idx);
    reg_t v;
    v = '0;
    for (int r = 0; r < DIM; r++) begin
      if (int'(coef_reg(r, r)) == idx) begin
        v[coef_lsb(r) +: SLOT_W] = SLOT_W'($unsigned(COEF_ONE));
      end
    end
    return v;
  endfunction

endpackage

// File: rtl/core/vt4_cfg_if.sv
// ----------------------------------------------------------------------------
// vt4_cfg_if: coefficient register write channel
// Carries the register index and 64-bit write data.
// ----------------------------------------------------------------------------
interface vt4_cfg_if;
  import vt4_pkg::*;

  logic     valid;
  logic     ready;
  reg_idx_t index;
  reg_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/vt4_vtx_if.sv
// ----------------------------------------------------------------------------
// vt4_vtx_if: vertex input channel
// Carries one homogeneous vertex per transaction.
// ----------------------------------------------------------------------------
interface vt4_vtx_if;
  import vt4_pkg::*;

  logic   valid;
  logic   ready;
  field_t in_x;
  field_t in_y;
  field_t in_z;
  field_t in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
                output ready);
endinterface

// File: rtl/core/vt4_res_if.sv
// ----------------------------------------------------------------------------
// vt4_res_if: transformed vertex output channel
// Carries the four transformed coordinates and the saturation flag.
// ----------------------------------------------------------------------------
interface vt4_res_if;
  import vt4_pkg::*;

  logic   valid;
  logic   ready;
  field_t out_x;
  field_t out_y;
  field_t out_z;
  field_t out_w;
  logic   saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output saturated, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
                input saturated, output ready);
endinterface

// File: rtl/core/vt4_cfg.sv
// ----------------------------------------------------------------------------
// vt4_cfg: coefficient register file
// Eight 64-bit registers, two matrix coefficients each, reset to identity.
// ----------------------------------------------------------------------------
module vt4_cfg (
  input  logic               clk,
  input  logic               rst_n,
  vt4_cfg_if.sink            cfg_wr,
  output vt4_pkg::coef_mat_t coef
);
  import vt4_pkg::*;

  reg_t regs_r   [NUM_REGS];
  reg_t regs_nxt [NUM_REGS];

  // Accept a write in every cycle
  assign cfg_wr.ready = 1'b1;

  // Update the addressed register
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    if (cfg_wr.valid) begin
      regs_nxt[cfg_wr.index] = cfg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= reg_reset(i);
      end
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Unpack coefficients: low COORD_WIDTH bits of each slot, two's complement
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        coef[r][c] = coord_t'(regs_r[coef_reg(r, c)][coef_lsb(c) +: COORD_WIDTH]);
      end
    end
  end

endmodule

// File: rtl/core/vt4_cell.sv
// ----------------------------------------------------------------------------
// vt4_cell: one column cell of the transform chain
// Multiplies the leading vertex component by one matrix column, adds the
// products to the running row sums and hands sums and rotated vertex on.
// ----------------------------------------------------------------------------
module vt4_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  vt4_pkg::coord_vec_t up_vtx,
  input  vt4_pkg::acc_vec_t   up_sum,
  input  vt4_pkg::coord_vec_t coef_col,
  output logic                dn_valid,
  input  logic                dn_ready,
  output vt4_pkg::coord_vec_t dn_vtx,
  output vt4_pkg::acc_vec_t   dn_sum
);
  import vt4_pkg::*;

  logic       va_r, va_nxt;
  logic       vb_r, vb_nxt;
  logic       ready_a, ready_b;
  prod_vec_t  prod_r, prod_nxt;
  acc_vec_t   suma_r, suma_nxt;
  coord_vec_t vtxa_r, vtxa_nxt;
  acc_vec_t   sumb_r, sumb_nxt;
  coord_vec_t vtxb_r, vtxb_nxt;

  // Each stage takes new data when empty or when its successor advances
  assign ready_b  = !vb_r || dn_ready;
  assign ready_a  = !va_r || ready_b;
  assign up_ready = ready_a;

  assign va_nxt = ready_a ? up_valid : va_r;
  assign vb_nxt = ready_b ? va_r : vb_r;

  // Multiply stage: column times leading component, rotate the vertex
  always_comb begin
    prod_nxt = prod_r;
    suma_nxt = suma_r;
    vtxa_nxt = vtxa_r;
    if (ready_a && up_valid) begin
      for (int r = 0; r < DIM; r++) begin
        prod_nxt[r] = coef_col[r] * up_vtx[0];
        suma_nxt[r] = up_sum[r];
        vtxa_nxt[r] = up_vtx[(r + 1) % DIM];
      end
    end
  end

  // Accumulate stage: add products into the row sums
  always_comb begin
    sumb_nxt = sumb_r;
    vtxb_nxt = vtxb_r;
    if (ready_b && va_r) begin
      for (int r = 0; r < DIM; r++) begin
        sumb_nxt[r] = suma_r[r] + acc_t'(prod_r[r]);
      end
      vtxb_nxt = vtxa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    suma_r <= suma_nxt;
    vtxa_r <= vtxa_nxt;
    sumb_r <= sumb_nxt;
    vtxb_r <= vtxb_nxt;
  end

  assign dn_valid = vb_r;
  assign dn_vtx   = vtxb_r;
  assign dn_sum   = sumb_r;

`ifndef ASSERT_OFF
  // A stalled result keeps its first and last row sums
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && !dn_ready |=> vb_r && $stable(sumb_r[0]) && $stable(sumb_r[DIM-1]))
    else $error("vt4_cell: stalled sums changed");

  // A product never gets lost between the stages
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && ready_b |=> vb_r)
    else $error("vt4_cell: product stage dropped a transaction");

  // The accumulate stage adds exactly one product to the incoming row 0 sum
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && ready_b |=> sumb_r[0] == $past(suma_r[0]) + acc_t'($past(prod_r[0])))
    else $error("vt4_cell: row sum mismatch");
`endif

endmodule

// File: rtl/core/vt4_round.sv
// ----------------------------------------------------------------------------
// vt4_round: rounding, saturation and output register
// Drops the fraction bits of each exact row sum, clips to the coordinate
// range and holds the result for the output channel.
// ----------------------------------------------------------------------------
module vt4_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  vt4_pkg::acc_vec_t up_sum,
  vt4_res_if.source         out_res
);
  import vt4_pkg::*;

  localparam int HI_LSB = FRAC_BITS + COORD_WIDTH - 1;

  logic       out_valid_r, out_valid_nxt;
  coord_t     res_r   [DIM];
  coord_t     res_nxt [DIM];
  logic       sat_r, sat_nxt;
  logic       fits    [DIM];
  coord_t     clip    [DIM];
  logic       load;

  assign up_ready      = !out_valid_r || out_res.ready;
  assign load          = up_ready && up_valid;
  assign out_valid_nxt = up_ready ? up_valid : out_valid_r;

  // Check range, then take the integer-aligned window or the clip value
  always_comb begin
    res_nxt = res_r;
    sat_nxt = sat_r;
    for (int r = 0; r < DIM; r++) begin
      fits[r] = (&up_sum[r][ACC_W-1:HI_LSB]) || !(|up_sum[r][ACC_W-1:HI_LSB]);
      clip[r] = up_sum[r][ACC_W-1] ? COORD_MIN : COORD_MAX;
    end
    if (load) begin
      sat_nxt = 1'b0;
      for (int r = 0; r < DIM; r++) begin
        res_nxt[r] = fits[r] ? coord_t'(up_sum[r][FRAC_BITS +: COORD_WIDTH]) : clip[r];
        sat_nxt    = sat_nxt || !fits[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    sat_r <= sat_nxt;
  end

  // Drive the channel, sign-extending each coordinate
  assign out_res.valid     = out_valid_r;
  assign out_res.out_x     = field_t'(res_r[0]);
  assign out_res.out_y     = field_t'(res_r[1]);
  assign out_res.out_z     = field_t'(res_r[2]);
  assign out_res.out_w     = field_t'(res_r[3]);
  assign out_res.saturated = sat_r;

endmodule

// File: rtl/core/vertex_transform_4x4.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4: homogeneous 4x4 matrix times vertex, Q16.16
// Chain of four column cells followed by a rounding and saturation stage.
// ----------------------------------------------------------------------------
// One vertex is accepted per clock cycle and one transformed vertex leaves per
// cycle once the pipeline is full, as long as the output channel is ready;
// each of the four column cells registers its 32x32 multiplies and then its
// exact 67-bit accumulate, and the rounding stage registers the result. Sums
// are exact, rounded to nearest with halves going towards plus infinity, then
// clipped to the 32-bit range with the saturated flag set when any of the four
// coordinates was clipped. The matrix resets to identity and is loaded through
// the configuration channel, which is always ready; write it only while no
// vertex is in flight.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 (
  input  logic      clk,
  input  logic      rst_n,
  vt4_cfg_if.sink   cfg_wr,
  vt4_vtx_if.sink   in_vtx,
  vt4_res_if.source out_res
);
  import vt4_pkg::*;

  coef_mat_t  coef;
  coord_vec_t coef_col  [DIM];
  logic       cell_valid [DIM+1];
  logic       cell_ready [DIM+1];
  coord_vec_t link_vtx  [DIM+1];
  acc_vec_t   link_sum  [DIM+1];

  vt4_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .coef   (coef)
  );

  // Transpose rows into the column each cell multiplies by
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      for (int r = 0; r < DIM; r++) begin
        coef_col[k][r] = coef[r][k];
      end
    end
  end

  // Feed the head of the chain; sums start at the rounding half
  assign cell_valid[0] = in_vtx.valid;
  assign in_vtx.ready  = cell_ready[0];
  assign link_vtx[0]   = '{coord_t'(in_vtx.in_x[COORD_WIDTH-1:0]),
                           coord_t'(in_vtx.in_y[COORD_WIDTH-1:0]),
                           coord_t'(in_vtx.in_z[COORD_WIDTH-1:0]),
                           coord_t'(in_vtx.in_w[COORD_WIDTH-1:0])};
  assign link_sum[0]   = '{default: ROUND_HALF};

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    vt4_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cell_valid[k]),
      .up_ready (cell_ready[k]),
      .up_vtx   (link_vtx[k]),
      .up_sum   (link_sum[k]),
      .coef_col (coef_col[k]),
      .dn_valid (cell_valid[k+1]),
      .dn_ready (cell_ready[k+1]),
      .dn_vtx   (link_vtx[k+1]),
      .dn_sum   (link_sum[k+1])
    );
  end

  vt4_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cell_valid[DIM]),
    .up_ready (cell_ready[DIM]),
    .up_sum   (link_sum[DIM]),
    .out_res  (out_res)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vertex_transform_4x4
// Streams vertices through the block under several coefficient matrices and
// several patterns of sender gaps and receiver back-pressure. A local model
// of the fixed-point transform predicts every transformed vertex, and the
// monitor compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import vt4_pkg::*;

  localparam int          CLK_PERIOD        = 20;
  localparam int          RESET_CYCLES      = 11;
  localparam int          PIPE_LATENCY      = 9;
  localparam int          DRAIN_CYCLES      = 2 * PIPE_LATENCY + 4;
  localparam int          LONG_STALL_CYCLES = 200;
  localparam int          RANDOM_PER_MATRIX = 59;
  localparam longint      TIMEOUT_NS        = 4_000_000;

  // Coefficient register indexes
  typedef enum logic [IDX_W-1:0] {
    ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
    ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
  } coef_reg_t;

  typedef struct {
    field_t x;
    field_t y;
    field_t z;
    field_t w;
  } vertex_t;

  typedef struct {
    field_t x;
    field_t y;
    field_t z;
    field_t w;
    logic   saturated;
  } xformed_t;

  logic clk;
  logic rst_n;

  vt4_cfg_if cfg_if ();
  vt4_vtx_if vtx_if ();
  vt4_res_if res_if ();

  vertex_transform_4x4 u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_if),
    .in_vtx  (vtx_if),
    .out_res (res_if)
  );

  // Local copy of the coefficient registers and the matrix to load next
  reg_t        coef_regs [NUM_REGS];
  field_t      next_mat  [DIM][DIM];

  vertex_t     pending_vertices [$];
  xformed_t    expected_xforms  [$];

  int unsigned send_idle_pct     = 0;
  int unsigned recv_stall_pct    = 0;
  bit          hold_inputs       = 1'b0;
  bit          long_stall_toggle = 1'b0;
  bit          long_stall_seen   = 1'b0;
  int          stall_left        = 0;
  int          error_count       = 0;

  vertex_t     offered_vtx;
  vertex_t     next_vtx;
  xformed_t    want;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // Transform one vertex: exact row sums, round half up, clip to 32 bits
  function automatic xformed_t transform_vertex(input vertex_t v);
    coord_t   vc [DIM];
    field_t   res [DIM];
    reg_t     r;
    coord_t   c;
    prod_t    pa;
    prod_t    pb;
    acc_t     sum;
    acc_t     rounded;
    acc_t     sat_hi;
    acc_t     sat_lo;
    xformed_t o;
    vc[0]  = v.x;
    vc[1]  = v.y;
    vc[2]  = v.z;
    vc[3]  = v.w;
    sat_hi = COORD_MAX;
    sat_lo = COORD_MIN;
    o.saturated = 1'b0;
    for (int row = 0; row < DIM; row++) begin
      sum = '0;
      for (int col = 0; col < DIM; col++) begin
        r   = coef_regs[2 * row + col / 2];
        c   = $signed(r[(col % 2) * SLOT_W +: COORD_WIDTH]);
        pa  = c;
        pb  = vc[col];
        sum = sum + pa * pb;
      end
      rounded = (sum + ROUND_HALF) >>> FRAC_BITS;
      if (rounded > sat_hi) begin
        res[row]    = COORD_MAX;
        o.saturated = 1'b1;
      end else if (rounded < sat_lo) begin
        res[row]    = COORD_MIN;
        o.saturated = 1'b1;
      end else begin
        res[row] = rounded[COORD_WIDTH-1:0];
      end
    end
    o.x = res[0];
    o.y = res[1];
    o.z = res[2];
    o.w = res[3];
    return o;
  endfunction

  // Random value: mostly small or mid magnitudes, some full-range and corner values
  function automatic field_t rand_value(input int unsigned wide_pct);
    logic [31:0] r;
    int unsigned pick;
    r    = $urandom;
    pick = $urandom_range(99);
    if (pick < 8) begin
      case ($urandom_range(6))
        0:       return '0;
        1:       return COEF_ONE;
        2:       return -COEF_ONE;
        3:       return COORD_MAX;
        4:       return COORD_MIN;
        5:       return 32'sd1;
        default: return -32'sd1;
      endcase
    end
    if (pick < 8 + wide_pct) return field_t'(r);
    if (pick < 60) return field_t'($signed(r[23:0]));
    return field_t'($signed(r[19:0]));
  endfunction

  task automatic check_field(input string name, input field_t exp, input field_t act);
    if (act !== exp) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      error_count++;
    end
  endtask

  // Write one coefficient register and mirror it locally
  task automatic write_coef_reg(input reg_idx_t idx, input reg_t value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    coef_regs[idx] = value;
    cfg_if.valid  <= 1'b0;
  endtask

  // Wait until nothing is queued, offered or in flight, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_vertices.size() != 0 || vtx_if.valid || expected_xforms.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Load next_mat into all eight registers once the block is idle
  task automatic load_matrix();
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) begin
      write_coef_reg(reg_idx_t'(i),
                     {next_mat[i / 2][(i % 2) * 2 + 1], next_mat[i / 2][(i % 2) * 2]});
    end
  endtask

  task automatic load_uniform(input field_t c);
    for (int r = 0; r < DIM; r++)
      for (int k = 0; k < DIM; k++)
        next_mat[r][k] = c;
    load_matrix();
  endtask

  task automatic load_random(input int unsigned wide_pct);
    for (int r = 0; r < DIM; r++)
      for (int k = 0; k < DIM; k++)
        next_mat[r][k] = rand_value(wide_pct);
    load_matrix();
  endtask

  task automatic queue_vertex(input field_t x, input field_t y, input field_t z,
                              input field_t w);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.w = w;
    pending_vertices.push_back(v);
  endtask

  task automatic queue_random(input int n);
    @(negedge clk);
    repeat (n) queue_vertex(rand_value(20), rand_value(20), rand_value(20), rand_value(20));
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Driver: predict on each accepted transaction, then offer the next vertex
  always @(posedge clk) begin
    if (!rst_n) begin
      vtx_if.valid <= 1'b0;
    end else begin
      if (vtx_if.valid && vtx_if.ready) begin
        offered_vtx.x = vtx_if.in_x;
        offered_vtx.y = vtx_if.in_y;
        offered_vtx.z = vtx_if.in_z;
        offered_vtx.w = vtx_if.in_w;
        expected_xforms.push_back(transform_vertex(offered_vtx));
      end
      // Hold an offer until it is taken; only a free slot may idle
      if (!vtx_if.valid || vtx_if.ready) begin
        if (pending_vertices.size() != 0 && !hold_inputs &&
            $urandom_range(99) >= send_idle_pct) begin
          next_vtx     = pending_vertices.pop_front();
          vtx_if.valid <= 1'b1;
          vtx_if.in_x  <= next_vtx.x;
          vtx_if.in_y  <= next_vtx.y;
          vtx_if.in_z  <= next_vtx.z;
          vtx_if.in_w  <= next_vtx.w;
        end else begin
          vtx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, then choose the next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_xforms.size() == 0) begin
          $error("result with no vertex pending: x=%0d y=%0d z=%0d w=%0d",
                 res_if.out_x, res_if.out_y, res_if.out_z, res_if.out_w);
          error_count++;
        end else begin
          want = expected_xforms.pop_front();
          check_field("out_x", want.x, res_if.out_x);
          check_field("out_y", want.y, res_if.out_y);
          check_field("out_z", want.z, res_if.out_z);
          check_field("out_w", want.w, res_if.out_w);
          check_field("saturated", field_t'(want.saturated), field_t'(res_if.saturated));
        end
      end
      // Start a long hold-off when requested
      if (long_stall_toggle != long_stall_seen) begin
        long_stall_seen = long_stall_toggle;
        stall_left      = LONG_STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_n        = 1'b0;
    vtx_if.valid = 1'b0;
    vtx_if.in_x  = '0;
    vtx_if.in_y  = '0;
    vtx_if.in_z  = '0;
    vtx_if.in_w  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    res_if.ready = 1'b0;

    // Identity matrix after reset
    foreach (coef_regs[i]) coef_regs[i] = '0;
    coef_regs[ROW0_COLS01][SLOT_W-1:0]      = COEF_ONE;
    coef_regs[ROW1_COLS01][REG_W-1:SLOT_W]  = COEF_ONE;
    coef_regs[ROW2_COLS23][SLOT_W-1:0]      = COEF_ONE;
    coef_regs[ROW3_COLS23][REG_W-1:SLOT_W]  = COEF_ONE;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset matrix passes vertices through unchanged
    @(negedge clk);
    queue_vertex('0, '0, '0, '0);
    queue_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    queue_vertex(COEF_ONE, -COEF_ONE, 32'sd1, -32'sd1);

    // One ulp everywhere: rounding of exact halves and near-halves
    load_uniform(32'sd1);
    queue_vertex(32'sh8000, '0, '0, '0);
    queue_vertex(-32'sh8000, '0, '0, '0);
    queue_vertex(32'sh7fff, '0, '0, '0);
    queue_vertex(-32'sh8001, '0, '0, '0);
    queue_vertex(32'sh18000, 32'sh8000, 32'sh8000, 32'sh8000);

    // Largest positive coefficients: clipping both ways and cancelling terms
    load_uniform(COORD_MAX);
    queue_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    queue_vertex(COORD_MAX, COORD_MIN, '0, '0);
    queue_vertex(32'sd1, -32'sd1, COORD_MAX, COORD_MIN);

    // Most negative coefficients: the largest possible exact sum
    load_uniform(COORD_MIN);
    queue_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    queue_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_vertex(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);

    // All bits set: minus one ulp everywhere
    load_uniform(-32'sd1);
    queue_vertex(-32'sh8000, '0, '0, '0);
    queue_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);

    // Unit coefficients: results right at the edges of the range
    load_uniform(COEF_ONE);
    queue_vertex(COORD_MAX, 32'sd1, '0, '0);
    queue_vertex(COORD_MIN, -32'sd1, '0, '0);
    queue_vertex(COORD_MIN, '0, '0, '0);

    // Random phases over four idling patterns, two matrices each
    for (int ph = 0; ph < 4; ph++) begin
      for (int sub = 0; sub < 2; sub++) begin
        load_random(sub == 0 ? 5 : 40);
        case (ph)
          0:       set_idling(0, 0);
          1:       set_idling(53, 0);
          2:       set_idling(0, 53);
          default: set_idling(11, 11);
        endcase
        if (ph == 0 && sub == 0) begin
          queue_random(2 * RANDOM_PER_MATRIX);
          // Long receiver hold-off while the sender keeps offering
          @(negedge clk);
          long_stall_toggle = ~long_stall_toggle;
          while (pending_vertices.size() > RANDOM_PER_MATRIX / 2) @(negedge clk);
          // Pause the sender until every result is back
          hold_inputs = 1'b1;
          while (vtx_if.valid || expected_xforms.size() != 0) @(negedge clk);
          hold_inputs = 1'b0;
        end else begin
          queue_random(RANDOM_PER_MATRIX);
        end
      end
    end

    wait_idle();
    if (error_count == 0 && expected_xforms.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
